@@ rtl/mcwm_pkg.sv @@
package mcwm_pkg;

  // Field and register widths
  localparam int SPEED_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int STEP_W      = 16;
  localparam int KEY_SPEED_W = 15;
  localparam int SPIN_W      = 15;

  // Saturation bounds of a wheel speed
  localparam int SPEED_MAX = 32767;
  localparam int SPEED_MIN = -32768;

  // Register reset values
  localparam logic [STEP_W-1:0]      RAMP_UP_RESET   = 16'd262;
  localparam logic [STEP_W-1:0]      RAMP_DOWN_RESET = 16'd655;
  localparam logic [KEY_SPEED_W-1:0] KEY_SPEED_RESET = 15'd9006;
  localparam logic [SPIN_W-1:0]      SPIN_RESET      = 15'd7000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RAMP_UP    = 2'd0,
    REG_RAMP_DOWN  = 2'd1,
    REG_KEY_SPEED  = 2'd2,
    REG_SPIN_SPEED = 2'd3
  } cfg_reg_t;

  // Quarter-wave sine, 32 segments plus the end point, 32767 = 1.0
  localparam int TABLE_BITS = 5;
  localparam int TABLE_LAST = 32;
  localparam int SINE_MAG_W = 15;
  localparam int SINE_W     = 16;
  localparam int DELTA_W    = 11;

  localparam logic [SINE_MAG_W-1:0] QUARTER_SINE [0:TABLE_LAST] = '{
    15'd0,     15'd1608,  15'd3212,  15'd4808,  15'd6393,  15'd7962,  15'd9512,  15'd11039,
    15'd12539, 15'd14010, 15'd15446, 15'd16846, 15'd18204, 15'd19519, 15'd20787, 15'd22005,
    15'd23170, 15'd24279, 15'd25329, 15'd26319, 15'd27245, 15'd28105, 15'd28898, 15'd29621,
    15'd30273, 15'd30852, 15'd31356, 15'd31785, 15'd32137, 15'd32412, 15'd32609, 15'd32728,
    15'd32767
  };

  // Rotation products carry Q1.15 sine and cosine
  localparam int ROT_SHIFT = 15;

  // Datapath arithmetic widths
  localparam int MUL_W     = 17;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ROT_SUM_W = PROD_W + 1;
  localparam int ROT_W     = 19;
  localparam int R_W       = 17;
  localparam int WHEEL_W   = 21;

  typedef struct packed {
    logic load;
    logic key_mul;
    logic vel;
    logic rot1;
    logic rot2;
    logic yfin;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

@@ rtl/mcwm_in_if.sv @@
interface mcwm_in_if
  import mcwm_pkg::*;
#(
  parameter int ANGLE_BITS = 12
) ();

  logic                         valid;
  logic                         ready;
  logic                         key_forward;
  logic                         key_left;
  logic                         key_back;
  logic                         key_right;
  logic                         spin_flag;
  logic signed [SPEED_W-1:0]    stick_spin;
  logic signed [SPEED_W-1:0]    stick_x;
  logic signed [SPEED_W-1:0]    stick_y;
  logic        [ANGLE_BITS-1:0] heading;

  modport source (
    output valid, key_forward, key_left, key_back, key_right, spin_flag,
    output stick_spin, stick_x, stick_y, heading,
    input  ready
  );

  modport sink (
    input  valid, key_forward, key_left, key_back, key_right, spin_flag,
    input  stick_spin, stick_x, stick_y, heading,
    output ready
  );

endinterface

@@ rtl/mcwm_out_if.sv @@
interface mcwm_out_if
  import mcwm_pkg::*;
();

  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] wheel_one_speed;
  logic signed [SPEED_W-1:0] wheel_two_speed;
  logic signed [SPEED_W-1:0] wheel_three_speed;
  logic signed [SPEED_W-1:0] wheel_four_speed;

  modport source (
    output valid, wheel_one_speed, wheel_two_speed, wheel_three_speed, wheel_four_speed,
    input  ready
  );

  modport sink (
    input  valid, wheel_one_speed, wheel_two_speed, wheel_three_speed, wheel_four_speed,
    output ready
  );

endinterface

@@ rtl/mcwm_ctrl.sv @@
module mcwm_ctrl
  import mcwm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_KEY  = 7'b0000010,
    ST_VEL  = 7'b0000100,
    ST_ROT1 = 7'b0001000,
    ST_ROT2 = 7'b0010000,
    ST_YFIN = 7'b0100000,
    ST_MIX  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd.load    = in_valid && in_ready;
    cmd.key_mul = (state == ST_KEY);
    cmd.vel     = (state == ST_VEL);
    cmd.rot1    = (state == ST_ROT1);
    cmd.rot2    = (state == ST_ROT2);
    cmd.yfin    = (state == ST_YFIN);
    cmd.publish = (state == ST_MIX) && !status.out_busy;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_KEY;
      ST_KEY:  state_next = ST_VEL;
      ST_VEL:  state_next = ST_ROT1;
      ST_ROT1: state_next = ST_ROT2;
      ST_ROT2: state_next = ST_YFIN;
      ST_YFIN: state_next = ST_MIX;
      // hold until the output register is free
      ST_MIX:  if (!status.out_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/mcwm_sine.sv @@
module mcwm_sine
  import mcwm_pkg::*;
#(
  parameter int ANGLE_BITS = 12
) (
  input  logic                     clk,
  input  logic [ANGLE_BITS-1:0]    angle,
  output logic signed [SINE_W-1:0] value
);

  localparam int FRAC_BITS = ANGLE_BITS - 2 - TABLE_BITS;
  localparam int PHASE_W   = ANGLE_BITS - 1;
  localparam int IDX_W     = TABLE_BITS + 1;
  localparam int QUARTER   = 1 << (ANGLE_BITS - 2);

  logic [1:0]              quadrant;
  logic [ANGLE_BITS-3:0]   phase;
  logic [PHASE_W-1:0]      fold;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        idx_hi;
  logic [FRAC_BITS-1:0]    frac;
  logic [SINE_MAG_W-1:0]   lo;
  logic [SINE_MAG_W-1:0]   hi;

  logic [SINE_MAG_W-1:0]   lo_q;
  logic [DELTA_W-1:0]      delta_q;
  logic [FRAC_BITS-1:0]    frac_q;
  logic                    neg_q;

  logic [DELTA_W+FRAC_BITS-1:0] interp_prod;
  logic [SINE_MAG_W-1:0]        mag;

  assign quadrant = angle[ANGLE_BITS-1 -: 2];
  assign phase    = angle[ANGLE_BITS-3:0];

  // odd quadrants run the quarter wave backward
  always_comb begin
    if (quadrant[0]) begin
      fold = PHASE_W'(QUARTER) - {1'b0, phase};
    end else begin
      fold = {1'b0, phase};
    end
  end

  assign idx    = fold[PHASE_W-1:FRAC_BITS];
  assign frac   = fold[FRAC_BITS-1:0];
  assign idx_hi = (idx >= IDX_W'(TABLE_LAST)) ? IDX_W'(TABLE_LAST) : idx + 1'b1;
  assign lo     = QUARTER_SINE[idx];
  assign hi     = QUARTER_SINE[idx_hi];

  always_ff @(posedge clk) begin
    lo_q    <= lo;
    delta_q <= DELTA_W'(hi - lo);
    frac_q  <= frac;
    neg_q   <= quadrant[1];
  end

  assign interp_prod = delta_q * frac_q;
  assign mag = lo_q + SINE_MAG_W'(interp_prod[DELTA_W+FRAC_BITS-1:FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (neg_q) begin
      value <= -signed'({1'b0, mag});
    end else begin
      value <= signed'({1'b0, mag});
    end
  end

endmodule

@@ rtl/mcwm_dp.sv @@
module mcwm_dp
  import mcwm_pkg::*;
#(
  parameter int ANGLE_BITS     = 12,
  parameter int RAMP_FRAC_BITS = 15
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  output dp_status_t                status,
  input  logic [STEP_W-1:0]         ramp_up_step,
  input  logic [STEP_W-1:0]         ramp_down_step,
  input  logic [KEY_SPEED_W-1:0]    key_full_speed,
  input  logic [SPIN_W-1:0]         spin_speed,
  input  logic                      key_forward,
  input  logic                      key_left,
  input  logic                      key_back,
  input  logic                      key_right,
  input  logic                      spin_flag,
  input  logic signed [SPEED_W-1:0] stick_spin,
  input  logic signed [SPEED_W-1:0] stick_x,
  input  logic signed [SPEED_W-1:0] stick_y,
  input  logic [ANGLE_BITS-1:0]     heading,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic signed [SPEED_W-1:0] wheel_one_speed,
  output logic signed [SPEED_W-1:0] wheel_two_speed,
  output logic signed [SPEED_W-1:0] wheel_three_speed,
  output logic signed [SPEED_W-1:0] wheel_four_speed
);

  localparam int LEVEL_W    = RAMP_FRAC_BITS + 1;
  localparam int DIFF_W     = LEVEL_W + 1;
  localparam int RAMP_SUM_W = STEP_W + 2;
  localparam int RAMP_ONE   = 1 << RAMP_FRAC_BITS;
  localparam int KEY_BIAS   = RAMP_ONE - 1;
  localparam int ROT_BIAS   = (1 << ROT_SHIFT) - 1;
  localparam int QUARTER    = 1 << (ANGLE_BITS - 2);

  localparam logic signed [WHEEL_W-1:0] WHEEL_MAX = WHEEL_W'(SPEED_MAX);
  localparam logic signed [WHEEL_W-1:0] WHEEL_MIN = WHEEL_W'(SPEED_MIN);

  function automatic logic signed [SPEED_W-1:0] sat_speed(
    input logic signed [WHEEL_W-1:0] v
  );
    if (v > WHEEL_MAX) begin
      return SPEED_W'(SPEED_MAX);
    end else if (v < WHEEL_MIN) begin
      return SPEED_W'(SPEED_MIN);
    end
    return v[SPEED_W-1:0];
  endfunction

  // ramp levels, order forward, left, back, right
  logic [LEVEL_W-1:0]           levels [4];
  logic [LEVEL_W-1:0]           levels_next [4];
  logic signed [RAMP_SUM_W-1:0] ramp_sum [4];
  logic signed [RAMP_SUM_W-1:0] ramp_full;
  logic [3:0]                   held;

  // captured item fields
  logic                      spin_flag_q;
  logic signed [SPEED_W-1:0] stick_spin_q;
  logic signed [SPEED_W-1:0] stick_x_q;
  logic signed [SPEED_W-1:0] stick_y_q;
  logic [ANGLE_BITS-1:0]     heading_q;
  logic [ANGLE_BITS-1:0]     cos_angle;

  logic signed [SINE_W-1:0] sin_val;
  logic signed [SINE_W-1:0] cos_val;

  logic signed [DIFF_W-1:0] diff_fb;
  logic signed [DIFF_W-1:0] diff_rl;

  logic signed [MUL_W-1:0]  mul_a_x, mul_a_y, mul_b_x, mul_b_y;
  logic signed [PROD_W-1:0] mul_prod_a, mul_prod_b;
  logic signed [PROD_W-1:0] prod_a, prod_b;

  logic signed [PROD_W-1:0] key_bias_a, key_bias_b;
  logic signed [PROD_W-1:0] key_sum_a, key_sum_b;
  logic signed [PROD_W-1:0] key_shift_a, key_shift_b;

  logic signed [MUL_W-1:0]  vx, vy;
  logic signed [R_W-1:0]    r;
  logic signed [R_W-1:0]    spin_term;

  logic signed [ROT_SUM_W-1:0] rot_sum, rot_bias, rot_biased, rot_shift;
  logic signed [ROT_W-1:0]     x, y;

  logic signed [WHEEL_W-1:0] xw, yw, rw;
  logic signed [WHEEL_W-1:0] w1, w2, w3, w4;

  // ramp update on accept: step up or down, clamp to 0..1
  assign held      = {key_right, key_back, key_left, key_forward};
  assign ramp_full = RAMP_SUM_W'(RAMP_ONE);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (held[i]) begin
        ramp_sum[i] = signed'(RAMP_SUM_W'(levels[i])) + signed'(RAMP_SUM_W'(ramp_up_step));
      end else begin
        ramp_sum[i] = signed'(RAMP_SUM_W'(levels[i])) - signed'(RAMP_SUM_W'(ramp_down_step));
      end
      if (ramp_sum[i] > ramp_full) begin
        levels_next[i] = LEVEL_W'(RAMP_ONE);
      end else if (ramp_sum[i][RAMP_SUM_W-1]) begin
        levels_next[i] = '0;
      end else begin
        levels_next[i] = ramp_sum[i][LEVEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= '{default: '0};
    end else if (cmd.load) begin
      levels <= levels_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      spin_flag_q  <= spin_flag;
      stick_spin_q <= stick_spin;
      stick_x_q    <= stick_x;
      stick_y_q    <= stick_y;
      heading_q    <= heading;
    end
  end

  // sine and cosine come from the registered sine units, fed from the captured heading
  assign cos_angle = heading_q + ANGLE_BITS'(QUARTER);

  mcwm_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin (
    .clk   (clk),
    .angle (heading_q),
    .value (sin_val)
  );

  mcwm_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos (
    .clk   (clk),
    .angle (cos_angle),
    .value (cos_val)
  );

  assign diff_fb = signed'({1'b0, levels[0]}) - signed'({1'b0, levels[2]});
  assign diff_rl = signed'({1'b0, levels[3]}) - signed'({1'b0, levels[1]});

  // two shared multipliers: key speeds, then the four rotation products
  always_comb begin
    if (cmd.rot1) begin
      mul_a_x = vx;
      mul_a_y = MUL_W'(cos_val);
      mul_b_x = vy;
      mul_b_y = MUL_W'(sin_val);
    end else if (cmd.rot2) begin
      mul_a_x = vx;
      mul_a_y = MUL_W'(sin_val);
      mul_b_x = vy;
      mul_b_y = MUL_W'(cos_val);
    end else begin
      mul_a_x = signed'(MUL_W'(key_full_speed));
      mul_a_y = MUL_W'(diff_fb);
      mul_b_x = signed'(MUL_W'(key_full_speed));
      mul_b_y = MUL_W'(diff_rl);
    end
  end

  assign mul_prod_a = mul_a_x * mul_a_y;
  assign mul_prod_b = mul_b_x * mul_b_y;

  always_ff @(posedge clk) begin
    if (cmd.key_mul || cmd.rot1 || cmd.rot2) begin
      prod_a <= mul_prod_a;
      prod_b <= mul_prod_b;
    end
  end

  // key speeds, divided by full scale toward zero
  assign key_bias_a  = prod_a[PROD_W-1] ? PROD_W'(KEY_BIAS) : '0;
  assign key_bias_b  = prod_b[PROD_W-1] ? PROD_W'(KEY_BIAS) : '0;
  assign key_sum_a   = prod_a + key_bias_a;
  assign key_sum_b   = prod_b + key_bias_b;
  assign key_shift_a = key_sum_a >>> RAMP_FRAC_BITS;
  assign key_shift_b = key_sum_b >>> RAMP_FRAC_BITS;

  assign spin_term = spin_flag_q ? signed'(R_W'(spin_speed)) : '0;

  always_ff @(posedge clk) begin
    if (cmd.vel) begin
      vy <= signed'(MUL_W'(stick_y_q)) + signed'(key_shift_a[MUL_W-1:0]);
      vx <= signed'(MUL_W'(stick_x_q)) + signed'(key_shift_b[MUL_W-1:0]);
      r  <= spin_term + R_W'(stick_spin_q);
    end
  end

  // X takes the difference, Y the sum; both scale back by 2^15 toward zero
  always_comb begin
    if (cmd.yfin) begin
      rot_sum = ROT_SUM_W'(prod_a) + ROT_SUM_W'(prod_b);
    end else begin
      rot_sum = ROT_SUM_W'(prod_a) - ROT_SUM_W'(prod_b);
    end
  end

  assign rot_bias   = rot_sum[ROT_SUM_W-1] ? ROT_SUM_W'(ROT_BIAS) : '0;
  assign rot_biased = rot_sum + rot_bias;
  assign rot_shift  = rot_biased >>> ROT_SHIFT;

  always_ff @(posedge clk) begin
    if (cmd.rot2) begin
      x <= signed'(rot_shift[ROT_W-1:0]);
    end
    if (cmd.yfin) begin
      y <= signed'(rot_shift[ROT_W-1:0]);
    end
  end

  // mecanum mix
  assign xw = WHEEL_W'(x);
  assign yw = WHEEL_W'(y);
  assign rw = WHEEL_W'(r);
  assign w1 = yw + rw + xw;
  assign w2 = yw + rw - xw;
  assign w3 = rw - yw - xw;
  assign w4 = rw - yw + xw;

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      wheel_one_speed   <= sat_speed(w1);
      wheel_two_speed   <= sat_speed(w2);
      wheel_three_speed <= sat_speed(w3);
      wheel_four_speed  <= sat_speed(w4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

@@ rtl/mecanum_chassis_wheel_mixer_core.sv @@
// Mecanum wheel mixer: each accepted item is one control tick. The four key
// ramp levels step up or down and clamp to 0..1, the key speeds join the
// joystick vector, the vector is turned by the heading through an
// interpolated quarter-wave sine table, a spin term is added and the four
// wheel speeds come out saturated to 16 bits. The block takes no new item
// until the last one has been written to the result register: a sequencer
// steps two shared 17x17 multipliers through the two key speed products and
// then the four rotation products, two per cycle, with a step each for the
// velocity sums, the final scaling and the mix. The result register lets a
// finished item wait for the sink while the block returns to idle; a result
// not taken by the time the next one is ready holds the sequencer in its
// last step. Ramp levels reset to zero and the registers to their defaults;
// there is no clearing pass. Write the registers only while no item is in
// flight.
module mecanum_chassis_wheel_mixer_core
  import mcwm_pkg::*;
#(
  parameter int ANGLE_BITS     = 12,
  parameter int RAMP_FRAC_BITS = 15
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  mcwm_in_if.sink                in_item,
  mcwm_out_if.source             out_item
);

  logic [STEP_W-1:0]      ramp_up_step;
  logic [STEP_W-1:0]      ramp_down_step;
  logic [KEY_SPEED_W-1:0] key_full_speed;
  logic [SPIN_W-1:0]      spin_speed;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  // register file: take a write whenever the enable is high
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_up_step   <= RAMP_UP_RESET;
      ramp_down_step <= RAMP_DOWN_RESET;
      key_full_speed <= KEY_SPEED_RESET;
      spin_speed     <= SPIN_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_RAMP_UP:    ramp_up_step   <= cfg_data;
        REG_RAMP_DOWN:  ramp_down_step <= cfg_data;
        REG_KEY_SPEED:  key_full_speed <= cfg_data[KEY_SPEED_W-1:0];
        REG_SPIN_SPEED: spin_speed     <= cfg_data[SPIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.ready = in_ready;

  // sequencer: accept an item in idle, then step the datapath
  mcwm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_item.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: ramp state, sine units, shared multipliers, result register
  mcwm_dp #(
    .ANGLE_BITS     (ANGLE_BITS),
    .RAMP_FRAC_BITS (RAMP_FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .ramp_up_step      (ramp_up_step),
    .ramp_down_step    (ramp_down_step),
    .key_full_speed    (key_full_speed),
    .spin_speed        (spin_speed),
    .key_forward       (in_item.key_forward),
    .key_left          (in_item.key_left),
    .key_back          (in_item.key_back),
    .key_right         (in_item.key_right),
    .spin_flag         (in_item.spin_flag),
    .stick_spin        (in_item.stick_spin),
    .stick_x           (in_item.stick_x),
    .stick_y           (in_item.stick_y),
    .heading           (in_item.heading),
    .out_ready         (out_item.ready),
    .out_valid         (out_item.valid),
    .wheel_one_speed   (out_item.wheel_one_speed),
    .wheel_two_speed   (out_item.wheel_two_speed),
    .wheel_three_speed (out_item.wheel_three_speed),
    .wheel_four_speed  (out_item.wheel_four_speed)
  );

endmodule

@@ rtl/mcwm_check.sv @@
module mcwm_check
  import mcwm_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [SPEED_W-1:0] wheel_one_speed,
  input logic signed [SPEED_W-1:0] wheel_two_speed,
  input logic signed [SPEED_W-1:0] wheel_three_speed,
  input logic signed [SPEED_W-1:0] wheel_four_speed
);

  // one item in flight: drop ready right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an item was accepted");

  // a new result only comes out of the busy sequencer
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

  a_out_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(wheel_one_speed) && $stable(wheel_two_speed)
      && $stable(wheel_three_speed) && $stable(wheel_four_speed))
    else $error("output item changed while stalled");

endmodule

bind mecanum_chassis_wheel_mixer_core mcwm_check u_mcwm_check (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_item.valid),
  .in_ready          (in_item.ready),
  .out_valid         (out_item.valid),
  .out_ready         (out_item.ready),
  .wheel_one_speed   (out_item.wheel_one_speed),
  .wheel_two_speed   (out_item.wheel_two_speed),
  .wheel_three_speed (out_item.wheel_three_speed),
  .wheel_four_speed  (out_item.wheel_four_speed)
);
